// ===== rtl/core/packed_handle_table_defines.svh =====
// Assertion helpers for the RTL file that checks its own behavior.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef PACKED_HANDLE_TABLE_DEFINES_SVH
`define PACKED_HANDLE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pht_pkg.sv =====
`default_nettype none

package pht_pkg;

    localparam int CAPACITY  = 128;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int PAYLOAD_W = 64;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_UPDATE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD2,
        S_EXE
    } state_t;

    // One result transaction.
    typedef struct packed {
        status_t              status;
        logic [IDX_W-1:0]     out_handle;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [IDX_W-1:0]     dense_index;
        logic [CNT_W-1:0]     live_count;
    } res_t;

    // Everything the execute step needs, gathered from the read phases.
    typedef struct packed {
        action_t              act;
        logic [IDX_W-1:0]     hnd;
        logic [PAYLOAD_W-1:0] pl;
        logic [IDX_W-1:0]     slot;
        logic [IDX_W-1:0]     moved;
        logic [PAYLOAD_W-1:0] last_pay;
        logic [IDX_W-1:0]     slot_handle;
        logic [PAYLOAD_W-1:0] slot_pay;
        logic [IDX_W-1:0]     free_top;
        logic [CNT_W-1:0]     issued;
        logic [CNT_W-1:0]     freed;
    } ctx_t;

    // One write port per memory.
    typedef struct packed {
        logic                 pay_en;
        logic [IDX_W-1:0]     pay_addr;
        logic [PAYLOAD_W-1:0] pay_data;
        logic                 s2h_en;
        logic [IDX_W-1:0]     s2h_addr;
        logic [IDX_W-1:0]     s2h_data;
        logic                 h2s_en;
        logic [IDX_W-1:0]     h2s_addr;
        logic [IDX_W-1:0]     h2s_data;
        logic                 free_en;
        logic [IDX_W-1:0]     free_addr;
        logic [IDX_W-1:0]     free_data;
    } wr_t;

    typedef struct packed {
        logic [CNT_W-1:0] issued;
        logic [CNT_W-1:0] freed;
        wr_t              wr;
        res_t             res;
    } upd_t;

endpackage

`default_nettype wire

// ===== rtl/core/pht_chan_if.sv =====
`default_nettype none

interface pht_in_if;
    import pht_pkg::*;

    logic                 valid;
    logic                 ready;
    action_t              action;
    logic [IDX_W-1:0]     handle;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output action, output handle, output payload, input ready);
    modport sink (input valid, input action, input handle, input payload, output ready);
endinterface

interface pht_out_if;
    import pht_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [IDX_W-1:0]     out_handle;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [IDX_W-1:0]     dense_index;
    logic [CNT_W-1:0]     live_count;

    modport source (
        output valid, output status, output out_handle, output out_payload,
        output dense_index, output live_count, input ready
    );
    modport sink (
        input valid, input status, input out_handle, input out_payload,
        input dense_index, input live_count, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/pht_exec.sv =====
`default_nettype none

module pht_exec (
    input  wire pht_pkg::ctx_t ctx,
    output pht_pkg::upd_t      upd
);
    import pht_pkg::*;

    logic [CNT_W-1:0] live;
    logic             full;
    logic             live_ok;
    logic [IDX_W-1:0] new_handle;
    logic [IDX_W-1:0] tail;

    assign live = ctx.issued - ctx.freed;
    assign full = (live >= CNT_W'(CAPACITY));
    assign tail = live[IDX_W-1:0];

    // A handle is live when it was issued, its slot sits inside the packed
    // region and that slot points back at it.
    assign live_ok = (CNT_W'(ctx.hnd) < ctx.issued)
                  && (CNT_W'(ctx.slot) < live)
                  && (ctx.slot_handle == ctx.hnd);

    assign new_handle = (ctx.freed != '0) ? ctx.free_top : ctx.issued[IDX_W-1:0];

    always_comb
    begin
        upd                 = '0;
        upd.issued          = ctx.issued;
        upd.freed           = ctx.freed;
        upd.res.status      = ST_OK;
        upd.res.out_handle  = ctx.hnd;

        unique case (ctx.act)
            ACT_INSERT:
            begin
                if (full)
                begin
                    upd.res.status = ST_FULL;
                end
                else
                begin
                    upd.wr.pay_en      = 1'b1;
                    upd.wr.pay_addr    = tail;
                    upd.wr.pay_data    = ctx.pl;
                    upd.wr.s2h_en      = 1'b1;
                    upd.wr.s2h_addr    = tail;
                    upd.wr.s2h_data    = new_handle;
                    upd.wr.h2s_en      = 1'b1;
                    upd.wr.h2s_addr    = new_handle;
                    upd.wr.h2s_data    = tail;
                    upd.res.out_handle  = new_handle;
                    upd.res.dense_index = tail;
                    if (ctx.freed != '0)
                    begin
                        upd.freed = ctx.freed - 1'b1;
                    end
                    else
                    begin
                        upd.issued = ctx.issued + 1'b1;
                    end
                end
            end
            ACT_REMOVE, ACT_LOOKUP, ACT_UPDATE:
            begin
                if (!live_ok)
                begin
                    upd.res.status = ST_BAD;
                end
                else
                begin
                    upd.res.dense_index = ctx.slot;
                    if (ctx.act == ACT_REMOVE)
                    begin
                        // The last packed entry moves into the freed slot. When
                        // the removed entry is itself the last one, this writes
                        // each entry with its own value.
                        upd.wr.pay_en    = 1'b1;
                        upd.wr.pay_addr  = ctx.slot;
                        upd.wr.pay_data  = ctx.last_pay;
                        upd.wr.s2h_en    = 1'b1;
                        upd.wr.s2h_addr  = ctx.slot;
                        upd.wr.s2h_data  = ctx.moved;
                        upd.wr.h2s_en    = 1'b1;
                        upd.wr.h2s_addr  = ctx.moved;
                        upd.wr.h2s_data  = ctx.slot;
                        upd.wr.free_en   = 1'b1;
                        upd.wr.free_addr = ctx.freed[IDX_W-1:0];
                        upd.wr.free_data = ctx.hnd;
                        upd.freed        = ctx.freed + 1'b1;
                    end
                    else if (ctx.act == ACT_LOOKUP)
                    begin
                        upd.res.out_payload = ctx.slot_pay;
                    end
                    else
                    begin
                        upd.wr.pay_en   = 1'b1;
                        upd.wr.pay_addr = ctx.slot;
                        upd.wr.pay_data = ctx.pl;
                    end
                end
            end
            default:
            begin
                upd.res.status = ST_BAD;
            end
        endcase

        upd.res.live_count = upd.issued - upd.freed;
    end

endmodule

`default_nettype wire

// ===== rtl/core/packed_handle_table.sv =====
// A result is registered at the end of its request's execute step. A new request is
// taken only after the previous one has left execute. Each request makes two read
// passes over the single-read-port memories and one execute step with their write ports.
// A stalled result holds the execute cycle until the result register frees up.
// Reset clears the handle counters, the state machine and the result valid flag;
// the four memories keep no reset value and can be read before being written.
`default_nettype none
`include "packed_handle_table_defines.svh"

module packed_handle_table (
    input wire         clk,
    input wire         rst_n,
    pht_in_if.sink     req,
    pht_out_if.source  rsp
);
    import pht_pkg::*;

    // Control state.
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] issued_count_reg;
    logic [CNT_W-1:0] free_count_reg;
    logic             rsp_valid_reg;

    // Request captured at acceptance.
    action_t              act_reg;
    logic [IDX_W-1:0]     hnd_reg;
    logic [PAYLOAD_W-1:0] pl_reg;

    // The four stores. Each has one read port and one write port.
    logic [IDX_W-1:0]     h2s_mem  [CAPACITY];
    logic [IDX_W-1:0]     s2h_mem  [CAPACITY];
    logic [IDX_W-1:0]     free_mem [CAPACITY];
    logic [PAYLOAD_W-1:0] pay_mem  [CAPACITY];

    // Registered read data.
    logic [IDX_W-1:0]     h2s_rd_reg;
    logic [IDX_W-1:0]     s2h_rd_reg;
    logic [IDX_W-1:0]     free_rd_reg;
    logic [PAYLOAD_W-1:0] pay_rd_reg;

    // Values from the first read pass, kept while the second pass reuses the ports.
    logic [IDX_W-1:0]     slot_reg;
    logic [IDX_W-1:0]     moved_reg;
    logic [PAYLOAD_W-1:0] last_pay_reg;

    res_t res_reg;

    logic             accept;
    logic             first_rd;
    logic             second_rd;
    logic             exe_go;
    logic [CNT_W-1:0] live;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] free_top_idx;
    logic [IDX_W-1:0] s2h_ra;
    logic [IDX_W-1:0] pay_ra;
    ctx_t             ctx;
    upd_t             upd;

    assign live         = issued_count_reg - free_count_reg;
    assign last_idx     = live[IDX_W-1:0] - 1'b1;
    assign free_top_idx = free_count_reg[IDX_W-1:0] - 1'b1;
    assign accept       = req.valid && req.ready;

    // State machine: accept (first read pass), second read pass, execute.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        first_rd   = 1'b0;
        second_rd  = 1'b0;
        exe_go     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                first_rd  = req.valid;
                if (req.valid)
                begin
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                second_rd  = 1'b1;
                state_next = S_EXE;
            end
            S_EXE:
            begin
                // The result register must be free, or be emptied this cycle,
                // before the memories and counters are committed.
                exe_go = !rsp_valid_reg || rsp.ready;
                if (exe_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Read addresses. The first pass reads the handle map at the requested
    // handle, the back pointer and payload of the last packed entry, and the
    // top of the free stack. The second pass reads the back pointer and payload
    // at the slot that the handle map returned.
    assign s2h_ra = second_rd ? h2s_rd_reg : last_idx;
    assign pay_ra = second_rd ? h2s_rd_reg : last_idx;

    always_ff @(posedge clk)
    begin
        if (first_rd)
        begin
            h2s_rd_reg  <= h2s_mem[req.handle];
            free_rd_reg <= free_mem[free_top_idx];
        end
        if (first_rd || second_rd)
        begin
            s2h_rd_reg <= s2h_mem[s2h_ra];
            pay_rd_reg <= pay_mem[pay_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= req.action;
            hnd_reg <= req.handle;
            pl_reg  <= req.payload;
        end
        if (second_rd)
        begin
            slot_reg     <= h2s_rd_reg;
            moved_reg    <= s2h_rd_reg;
            last_pay_reg <= pay_rd_reg;
        end
    end

    assign ctx.act         = act_reg;
    assign ctx.hnd         = hnd_reg;
    assign ctx.pl          = pl_reg;
    assign ctx.slot        = slot_reg;
    assign ctx.moved       = moved_reg;
    assign ctx.last_pay    = last_pay_reg;
    assign ctx.slot_handle = s2h_rd_reg;
    assign ctx.slot_pay    = pay_rd_reg;
    assign ctx.free_top    = free_rd_reg;
    assign ctx.issued      = issued_count_reg;
    assign ctx.freed       = free_count_reg;

    pht_exec u_exec (
        .ctx (ctx),
        .upd (upd)
    );

    // Write back. Every write lands at the end of the execute cycle, so the next
    // request, whose first reads come in the idle state that follows, sees it.
    always_ff @(posedge clk)
    begin
        if (exe_go && upd.wr.pay_en)
        begin
            pay_mem[upd.wr.pay_addr] <= upd.wr.pay_data;
        end
        if (exe_go && upd.wr.s2h_en)
        begin
            s2h_mem[upd.wr.s2h_addr] <= upd.wr.s2h_data;
        end
        if (exe_go && upd.wr.h2s_en)
        begin
            h2s_mem[upd.wr.h2s_addr] <= upd.wr.h2s_data;
        end
        if (exe_go && upd.wr.free_en)
        begin
            free_mem[upd.wr.free_addr] <= upd.wr.free_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issued_count_reg <= '0;
            free_count_reg   <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (exe_go)
            begin
                issued_count_reg <= upd.issued;
                free_count_reg   <= upd.freed;
                rsp_valid_reg    <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exe_go)
        begin
            res_reg <= upd.res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = res_reg.status;
    assign rsp.out_handle  = res_reg.out_handle;
    assign rsp.out_payload = res_reg.out_payload;
    assign rsp.dense_index = res_reg.dense_index;
    assign rsp.live_count  = res_reg.live_count;

    // The free stack never holds more handles than were issued, and the packed
    // region never grows past the capacity.
    `PHT_ASSERT_NOW(a_counts_sane, 1'b1,
        (free_count_reg <= issued_count_reg) && (live <= CNT_W'(CAPACITY)),
        "handle counters out of range")

    // A table-full answer only comes back when the table really is full.
    `PHT_ASSERT_NOW(a_full_means_full, rsp.valid && (rsp.status == ST_FULL),
        rsp.live_count == CNT_W'(CAPACITY), "full status with room left")

    // An accepted transaction always moves on to the second read pass.
    `PHT_ASSERT_NEXT(a_accept_reads, accept, state_reg == S_RD2,
        "accepted transaction did not start its reads")

    // Handles are issued and never taken back.
    `PHT_ASSERT_NEXT(a_issued_grows, 1'b1, issued_count_reg >= $past(issued_count_reg),
        "issued handle count went down")

endmodule

`default_nettype wire

// ===== tb/sv/tb_packed_handle_table.sv =====
`timescale 1ns / 100ps

// Self-checking regression for the packed handle table. Requests go in on the req
// channel, one result transaction comes back per request on the rsp channel. A
// behavioral copy of the table runs next to the design: it is updated at the moment
// a request transaction is accepted, and the result it predicts is queued. Every
// result transaction that the design hands out is compared against the oldest
// queued prediction.
module tb_packed_handle_table;
    import pht_pkg::*;

    // Several times the slowest legal run: about 1150 requests, each one paying the
    // block's own handling plus the longest gap on both sides, plus the long hold.
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_LIMIT  = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pht_in_if  req ();
    pht_out_if rsp ();

    packed_handle_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the table. The arrays are zero-filled so that the liveness test
    // below never sees unknowns; the design's own memories can be read unwritten.
    logic [IDX_W-1:0]     shadow_h2s [CAPACITY] = '{default: '0};
    logic [IDX_W-1:0]     shadow_s2h [CAPACITY] = '{default: '0};
    logic [PAYLOAD_W-1:0] shadow_pay [CAPACITY] = '{default: '0};
    logic [IDX_W-1:0]     shadow_free[CAPACITY] = '{default: '0};
    logic [CNT_W-1:0]     shadow_issued = '0;
    logic [CNT_W-1:0]     shadow_freed  = '0;

    // Results predicted for accepted requests, oldest first.
    res_t pending_results[$];

    int  fault_count = 0;
    int  cycle_count = 0;
    // Random idling on the request side and on the result side.
    bit  src_idle = 1'b1;
    bit  snk_idle = 1'b1;
    // Number of cycles that the result side is asked to hold off in one stretch.
    int  hold_left = 0;

    function automatic int shadow_live();
        return int'(shadow_issued) - int'(shadow_freed);
    endfunction

    // Applies one accepted request to the shadow table and queues the result that
    // the design must return for it.
    task automatic apply_table_op(input action_t op, input logic [IDX_W-1:0] hnd,
                                  input logic [PAYLOAD_W-1:0] pl);
        res_t                 r;
        logic [CNT_W-1:0]     n;
        logic [IDX_W-1:0]     slot;
        logic [IDX_W-1:0]     last;
        logic [IDX_W-1:0]     moved;
        logic [IDX_W-1:0]     nh;
        logic [PAYLOAD_W-1:0] tmp;
        bit                   is_live;
        r = '0;
        r.status = ST_OK;
        r.out_handle = hnd;
        n = shadow_issued - shadow_freed;
        slot = shadow_h2s[hnd];
        // A handle is live when it was issued, its position lies in the dense region
        // and the back pointer at that position names it again.
        is_live = (hnd < shadow_issued) && (slot < n) && (shadow_s2h[slot] == hnd);
        if (op == ACT_INSERT)
        begin
            if (n >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                shadow_pay[n[IDX_W-1:0]] = pl;
                // Freed handles come back last in, first out, before new ones.
                if (shadow_freed != 0)
                begin
                    shadow_freed = shadow_freed - 1'b1;
                    nh = shadow_free[shadow_freed[IDX_W-1:0]];
                end
                else
                begin
                    nh = shadow_issued[IDX_W-1:0];
                    shadow_issued = shadow_issued + 1'b1;
                end
                shadow_s2h[n[IDX_W-1:0]] = nh;
                shadow_h2s[nh] = n[IDX_W-1:0];
                r.out_handle = nh;
                r.dense_index = n[IDX_W-1:0];
            end
        end
        else if (!is_live)
        begin
            r.status = ST_BAD;
        end
        else
        begin
            r.dense_index = slot;
            case (op)
                ACT_REMOVE:
                begin
                    // The last dense entry moves into the hole; for the last entry
                    // itself this is a move onto itself.
                    last = n[IDX_W-1:0] - 1'b1;
                    moved = shadow_s2h[last];
                    tmp = shadow_pay[slot];
                    shadow_pay[slot] = shadow_pay[last];
                    shadow_pay[last] = tmp;
                    shadow_s2h[slot] = moved;
                    shadow_s2h[last] = hnd;
                    shadow_h2s[moved] = slot;
                    shadow_free[shadow_freed[IDX_W-1:0]] = hnd;
                    shadow_freed = shadow_freed + 1'b1;
                end
                ACT_LOOKUP:
                begin
                    r.out_payload = shadow_pay[slot];
                end
                default:
                begin
                    shadow_pay[slot] = pl;
                end
            endcase
        end
        r.live_count = shadow_issued - shadow_freed;
        pending_results.push_back(r);
    endtask

    // Offers one request transaction and returns at the falling edge after it was
    // accepted. It is entered at a falling edge. With idling on, valid may first
    // drop for a random burst.
    task automatic send_req(input action_t op, input logic [IDX_W-1:0] hnd,
                            input logic [PAYLOAD_W-1:0] pl);
        int gap;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.action  <= op;
        req.handle  <= hnd;
        req.payload <= pl;
        do
            @(posedge clk);
        while (!req.ready);
        apply_table_op(op, hnd, pl);
        @(negedge clk);
    endtask

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly a handle that is live right now, otherwise any handle: freed ones,
    // ones never issued, and stale ones all land here.
    function automatic logic [IDX_W-1:0] pick_handle();
        int n;
        n = shadow_live();
        if (n > 0 && $urandom_range(0, 9) < 8)
            return shadow_s2h[$urandom_range(0, n - 1)];
        return IDX_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    // One random request; the weights are percentages, update takes the rest.
    task automatic send_random(input int w_insert, input int w_remove, input int w_lookup);
        int      pick;
        action_t op;
        pick = $urandom_range(0, 99);
        if (pick < w_insert)
            op = ACT_INSERT;
        else if (pick < w_insert + w_remove)
            op = ACT_REMOVE;
        else if (pick < w_insert + w_remove + w_lookup)
            op = ACT_LOOKUP;
        else
            op = ACT_UPDATE;
        send_req(op, pick_handle(), random_payload());
    endtask

    // Right after reset nothing is live: every handle must be refused. The first
    // two inserts issue handles 0 and 1, and the handle field of an insert is
    // ignored.
    task automatic test_empty_table();
        send_req(ACT_LOOKUP, 7'd0, '0);
        send_req(ACT_REMOVE, 7'd127, '1);
        send_req(ACT_UPDATE, 7'd85, {32'h5555_5555, 32'h5555_5555});
        send_req(ACT_INSERT, 7'd0, '0);
        send_req(ACT_INSERT, 7'd127, '1);
    endtask

    // Reads and writes through live handles, with the payload extremes.
    task automatic test_lookup_update();
        send_req(ACT_LOOKUP, 7'd0, '1);
        send_req(ACT_LOOKUP, 7'd1, '0);
        send_req(ACT_UPDATE, 7'd1, {32'hA5A5_A5A5, 32'h5A5A_5A5A});
        send_req(ACT_LOOKUP, 7'd1, '0);
        send_req(ACT_UPDATE, 7'd0, '1);
    endtask

    // Removing handle 0 from the front moves the last entry (handle 2) into dense
    // position 0. After that handle 0 is freed and every use of it is refused.
    task automatic test_remove_moves_last();
        send_req(ACT_INSERT, 7'd42, {32'hDEAD_0000, 32'h0000_BEEF});
        send_req(ACT_REMOVE, 7'd0, '0);
        send_req(ACT_LOOKUP, 7'd2, '0);
        send_req(ACT_LOOKUP, 7'd0, '0);
        send_req(ACT_REMOVE, 7'd0, '0);
        send_req(ACT_UPDATE, 7'd0, '1);
    endtask

    // Removing the last entry and then the only one are moves onto themselves. The
    // free stack then hands back 2, 1, 0 in that order before handle 3 is new.
    task automatic test_remove_only_and_reuse();
        send_req(ACT_REMOVE, 7'd1, '0);
        send_req(ACT_REMOVE, 7'd2, '0);
        send_req(ACT_INSERT, 7'd0, {32'h0123_4567, 32'h89AB_CDEF});
        send_req(ACT_INSERT, 7'd0, {32'hFEDC_BA98, 32'h7654_3210});
        send_req(ACT_INSERT, 7'd0, '1);
        send_req(ACT_INSERT, 7'd0, '0);
        send_req(ACT_LOOKUP, 7'd3, '1);
    endtask

    // Balanced traffic that keeps the table small and churns the free stack.
    task automatic test_random_churn(input int count);
        repeat (count) send_random(35, 25, 20);
    endtask

    // Insert-heavy traffic until the table is full, then inserts against a full
    // table mixed with removes that open one position at a time.
    task automatic test_fill_and_overflow();
        repeat (230) send_random(85, 5, 5);
        while (shadow_live() < CAPACITY)
            send_req(ACT_INSERT, pick_handle(), random_payload());
        repeat (5) send_req(ACT_INSERT, pick_handle(), random_payload());
        repeat (30) send_random(50, 20, 15);
    endtask

    // The result side holds off for a long stretch while requests keep coming, so
    // the block fills and has to stall its request side.
    task automatic test_output_backpressure();
        src_idle = 1'b0;
        hold_left = 300;
        repeat (40) send_random(30, 20, 25);
        src_idle = 1'b1;
    endtask

    // Remove-heavy traffic down to an empty table, then requests against it.
    task automatic test_drain();
        repeat (200) send_random(10, 70, 10);
        while (shadow_live() > 0)
            send_req(ACT_REMOVE, shadow_s2h[$urandom_range(0, shadow_live() - 1)], '0);
        repeat (10) send_random(0, 40, 30);
    endtask

    // The last part of the run goes at full rate on both sides.
    task automatic test_full_rate();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        repeat (300) send_random(35, 25, 20);
    endtask

    // Result side: drives ready at falling edges. A requested long hold comes
    // first, then any random stall burst in progress.
    initial
    begin : drive_rsp_ready
        int stall_left;
        stall_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else if (snk_idle && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Compares each accepted result transaction with the oldest prediction. Values
    // are sampled at the rising edge, before the design updates its outputs.
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("unexpected result: status %0d handle %0d index %0d live %0d",
                             rsp.status, rsp.out_handle, rsp.dense_index, rsp.live_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status || rsp.out_handle !== want.out_handle ||
                    rsp.out_payload !== want.out_payload ||
                    rsp.dense_index !== want.dense_index ||
                    rsp.live_count !== want.live_count)
                begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                    begin
                        $display("mismatch at %0t: expected status %0d handle %0d payload %h",
                                 $realtime, want.status, want.out_handle, want.out_payload);
                        $display("    index %0d live %0d; got status %0d handle %0d",
                                 want.dense_index, want.live_count, rsp.status,
                                 rsp.out_handle);
                        $display("    payload %h index %0d live %0d",
                                 rsp.out_payload, rsp.dense_index, rsp.live_count);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("packed_handle_table regression: fail");
            $finish;
        end
    end

    initial
    begin : run_regression
        req.valid   = 1'b0;
        req.action  = ACT_INSERT;
        req.handle  = '0;
        req.payload = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_lookup_update();
        test_remove_moves_last();
        test_remove_only_and_reuse();
        test_random_churn(220);
        test_fill_and_overflow();
        test_output_backpressure();
        test_drain();
        test_random_churn(60);
        test_full_rate();
        req.valid <= 1'b0;

        // Let the last results drain, then give stray transactions time to show up.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (fault_count == 0)
            $display("packed_handle_table regression: pass");
        else
            $display("packed_handle_table regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pht_pkg.sv
rtl/core/pht_chan_if.sv
rtl/core/pht_exec.sv
rtl/core/packed_handle_table.sv
tb/sv/tb_packed_handle_table.sv
